### hw/rtl/aes256_pkg.sv
package aes256_pkg;

   localparam int NumRounds = 14;

   typedef logic [127:0] block_type;
   typedef logic [1:0]   csr_index_type;

   localparam logic [1:0] CsrKeyWord0 = 2'd0;
   localparam logic [1:0] CsrKeyWord1 = 2'd1;
   localparam logic [1:0] CsrKeyWord2 = 2'd2;
   localparam logic [1:0] CsrKeyWord3 = 2'd3;

   localparam logic [7:0] GfPoly = 8'h1b;

   localparam logic [7:0] SBOX [256] = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
   };

   function automatic logic [7:0] gf_double(input logic [7:0] v);
      gf_double = {v[6:0], 1'b0} ^ (v[7] ? GfPoly : 8'h00);
   endfunction

   function automatic logic [31:0] sub_word(input logic [31:0] w);
      sub_word = {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
   endfunction

endpackage

### hw/rtl/aes256_round.sv
// one cipher round, registered; also carries the round-key window forward
module aes256_round (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   last_round,
   input  logic                   sub_only,
   input  logic [7:0]             rcon,
   input  logic                   in_valid,
   input  aes256_pkg::block_type  in_state,
   input  logic [255:0]           in_keys,
   output logic                   out_valid,
   output aes256_pkg::block_type  out_state,
   output logic [255:0]           out_keys
);
   import aes256_pkg::*;

   logic                   valid_ff;
   block_type              state_ff, state_in;
   logic [255:0]           keys_ff, keys_in;
   logic [7:0]             sb [16];
   logic [7:0]             mc [16];
   logic [127:0]           rk_next;
   logic [31:0]            w [8];
   logic [31:0]            t0;

   // window holds words w[i..i+7]; the round uses the upper four as key
   always_comb begin
      for (int i = 0; i < 8; i++) w[i] = in_keys[32*i +: 32];
      // words at 8k+4 take subword alone, words at 8k rotate and add rcon
      t0 = sub_only ? sub_word(w[7])
                    : (sub_word({w[7][7:0], w[7][31:8]}) ^ {24'h0, rcon});
      rk_next[31:0]   = w[0] ^ t0;
      rk_next[63:32]  = w[1] ^ rk_next[31:0];
      rk_next[95:64]  = w[2] ^ rk_next[63:32];
      rk_next[127:96] = w[3] ^ rk_next[95:64];
      // slide the window forward by four words
      keys_in = {rk_next, in_keys[255:128]};
   end

   always_comb begin
      for (int c = 0; c < 4; c++)
         for (int r = 0; r < 4; r++)
            sb[4*c+r] = SBOX[in_state[8*(4*((c+r)%4)+r) +: 8]];
      for (int c = 0; c < 4; c++) begin
         logic [7:0] a, b, d, e, s;
         a = sb[4*c]; b = sb[4*c+1]; d = sb[4*c+2]; e = sb[4*c+3];
         s = a ^ b ^ d ^ e;
         mc[4*c]   = a ^ s ^ gf_double(a ^ b);
         mc[4*c+1] = b ^ s ^ gf_double(b ^ d);
         mc[4*c+2] = d ^ s ^ gf_double(d ^ e);
         mc[4*c+3] = e ^ s ^ gf_double(e ^ a);
      end
      for (int i = 0; i < 16; i++)
         state_in[8*i +: 8] = (last_round ? sb[i] : mc[i]) ^ in_keys[128 + 8*i +: 8];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
      state_ff <= state_in;
      keys_ff  <= keys_in;
   end

   assign out_valid = valid_ff;
   assign out_state = state_ff;
   assign out_keys  = keys_ff;

endmodule

### hw/rtl/aes256_block_encrypt.sv
// pipeline from start to rsp_valid: one initial key-add stage, then one
// register stage per round for the 14 rounds
// throughput: one block per cycle; no stall, results stream out in order
// reset: clears pipeline valid bits and the key registers to zero
// the receiver cannot stall; rsp_valid is a one-cycle strobe
module aes256_block_encrypt (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   output logic         busy,
   input  logic [63:0]  req_plaintext_low,
   input  logic [63:0]  req_plaintext_high,
   output logic         rsp_valid,
   output logic [63:0]  rsp_ciphertext_low,
   output logic [63:0]  rsp_ciphertext_high,
   input  logic         csr_write,
   input  logic [1:0]   csr_index,
   input  logic [63:0]  csr_data
);
   import aes256_pkg::*;

   logic [63:0]  key_ff [4];
   logic         v0_ff;
   block_type    s0_ff;
   logic [255:0] k0_ff;
   logic         v [NumRounds+1];
   block_type    s [NumRounds+1];
   logic [255:0] k [NumRounds+1];

   localparam logic [7:0] RCON [NumRounds] = '{
      8'h01, 8'h00, 8'h02, 8'h00, 8'h04, 8'h00, 8'h08,
      8'h00, 8'h10, 8'h00, 8'h20, 8'h00, 8'h40, 8'h00};

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 4; i++) key_ff[i] <= '0;
         v0_ff <= 1'b0;
      end else begin
         if (csr_write) begin
            case (csr_index)
               CsrKeyWord0: key_ff[0] <= csr_data;
               CsrKeyWord1: key_ff[1] <= csr_data;
               CsrKeyWord2: key_ff[2] <= csr_data;
               CsrKeyWord3: key_ff[3] <= csr_data;
               default: ;
            endcase
         end
         v0_ff <= start;
      end
      s0_ff <= {req_plaintext_high, req_plaintext_low} ^ {key_ff[1], key_ff[0]};
      k0_ff <= {key_ff[3], key_ff[2], key_ff[1], key_ff[0]};
   end

   assign v[0] = v0_ff;
   assign s[0] = s0_ff;
   assign k[0] = k0_ff;

   // round r uses key words 4r..4r+3; window after round r-1 holds 4(r-1)..4r+3
   for (genvar r = 0; r < NumRounds; r++) begin : g_round
      aes256_round u_round (
         .clock      (clock),
         .reset      (reset),
         .last_round (r == NumRounds - 1),
         .sub_only   ((r % 2) == 1),
         .rcon       (RCON[r]),
         .in_valid   (v[r]),
         .in_state   (s[r]),
         .in_keys    (k[r]),
         .out_valid  (v[r+1]),
         .out_state  (s[r+1]),
         .out_keys   (k[r+1])
      );
   end

   assign busy                = 1'b0;
   assign rsp_valid           = v[NumRounds];
   assign rsp_ciphertext_low  = s[NumRounds][63:0];
   assign rsp_ciphertext_high = s[NumRounds][127:64];

   a_busy_low: assert property (@(posedge clock) !busy) else $error("busy set");
   a_first_stage: assert property (@(posedge clock) disable iff (reset)
      start |=> v[0]) else $error("item lost at entry");
   a_latency: assert property (@(posedge clock) disable iff (reset)
      v[0] |-> ##14 rsp_valid) else $error("pipeline dropped an item");

endmodule

### tb/sv/tb.sv
`timescale 1ns / 1ps

module tb;
   import aes256_pkg::*;

   localparam int Latency   = 15;
   localparam int CycleLimit = 400000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic [63:0] req_plaintext_low = '0;
   logic [63:0] req_plaintext_high = '0;
   logic        rsp_valid;
   logic [63:0] rsp_ciphertext_low;
   logic [63:0] rsp_ciphertext_high;
   logic        csr_write = 1'b0;
   logic [1:0]  csr_index = '0;
   logic [63:0] csr_data = '0;

   aes256_block_encrypt uut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_plaintext_low(req_plaintext_low), .req_plaintext_high(req_plaintext_high),
      .rsp_valid(rsp_valid), .rsp_ciphertext_low(rsp_ciphertext_low),
      .rsp_ciphertext_high(rsp_ciphertext_high),
      .csr_write(csr_write), .csr_index(csr_index), .csr_data(csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   logic [63:0] key_copy [4];
   logic [127:0] ciphertext_queue [$];
   int mismatch_count = 0;
   int cycle_count = 0;

   localparam logic [7:0] SubTable [256] = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
   };

   function automatic logic [7:0] xtime(input logic [7:0] v);
      logic [7:0] shifted;
      shifted = {v[6:0], 1'b0};
      return v[7] ? (shifted ^ 8'h1b) : shifted;
   endfunction

   // bytes are little-endian: byte i in bits 8i+7:8i
   function automatic logic [127:0] encrypt_block(input logic [127:0] plain);
      logic [7:0] sched [240];
      logic [7:0] st [16];
      logic [7:0] prev [16];
      logic [7:0] t [4];
      logic [7:0] rcon;
      logic [7:0] tmp, all_x;
      logic [127:0] cipher;
      rcon = 8'h01;
      for (int i = 0; i < 32; i++) sched[i] = key_copy[i / 8][8 * (i % 8) +: 8];
      for (int w = 8; w < 60; w++) begin
         for (int b = 0; b < 4; b++) t[b] = sched[4 * (w - 1) + b];
         if (w % 8 == 0) begin
            tmp = t[0];
            t[0] = SubTable[t[1]] ^ rcon;
            t[1] = SubTable[t[2]];
            t[2] = SubTable[t[3]];
            t[3] = SubTable[tmp];
            rcon = xtime(rcon);
         end else if (w % 8 == 4) begin
            for (int b = 0; b < 4; b++) t[b] = SubTable[t[b]];
         end
         for (int b = 0; b < 4; b++) sched[4 * w + b] = sched[4 * (w - 8) + b] ^ t[b];
      end
      for (int i = 0; i < 16; i++) st[i] = plain[8 * i +: 8] ^ sched[i];
      for (int r = 1; r <= 14; r++) begin
         prev = st;
         for (int c = 0; c < 4; c++)
            for (int w = 0; w < 4; w++)
               st[4 * c + w] = SubTable[prev[4 * ((c + w) % 4) + w]];
         if (r < 14) begin
            for (int c = 0; c < 4; c++) begin
               prev = st;
               all_x = prev[4*c] ^ prev[4*c+1] ^ prev[4*c+2] ^ prev[4*c+3];
               for (int w = 0; w < 4; w++)
                  st[4*c+w] = prev[4*c+w] ^ all_x
                              ^ xtime(prev[4*c+w] ^ prev[4*c+(w+1)%4]);
            end
         end
         for (int i = 0; i < 16; i++) st[i] ^= sched[16 * r + i];
      end
      for (int i = 0; i < 16; i++) cipher[8 * i +: 8] = st[i];
      return cipher;
   endfunction

   always @(posedge clock) begin
      logic [127:0] want;
      cycle_count <= cycle_count + 1;
      if (cycle_count > CycleLimit) begin
         $display("CHECKS FAILED");
         $finish;
      end else if (!reset && rsp_valid) begin
         if (ciphertext_queue.size() == 0) begin
            mismatch_count <= mismatch_count + 1;
            if (mismatch_count < 10) $display("unexpected result %h %h",
               rsp_ciphertext_high, rsp_ciphertext_low);
         end else begin
            want = ciphertext_queue.pop_front();
            if (want[63:0] !== rsp_ciphertext_low || want[127:64] !== rsp_ciphertext_high) begin
               mismatch_count <= mismatch_count + 1;
               if (mismatch_count < 10)
                  $display("mismatch: expected %h %h got %h %h", want[127:64], want[63:0],
                     rsp_ciphertext_high, rsp_ciphertext_low);
            end
         end
      end
   end

   function automatic int gap_length();
      return ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 2);
   endfunction

   // start stays high across back-to-back items
   task automatic send_block(input logic [63:0] lo, input logic [63:0] hi, input bit gaps);
      int n;
      if (gaps) begin
         n = gap_length();
         if (n > 0) begin
            start <= 1'b0;
            repeat (n) @(posedge clock);
         end
      end
      start <= 1'b1;
      req_plaintext_low <= lo;
      req_plaintext_high <= hi;
      do @(posedge clock); while (busy);
      ciphertext_queue.push_back(encrypt_block({hi, lo}));
   endtask

   task automatic drain();
      start <= 1'b0;
      @(posedge clock);
      while (ciphertext_queue.size() != 0) @(posedge clock);
      repeat (Latency + 2) @(posedge clock);
   endtask

   task automatic write_key(input csr_index_type idx, input logic [63:0] value);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      @(posedge clock);
      csr_write <= 1'b0;
      key_copy[idx] = value;
      @(posedge clock);
   endtask

   task automatic load_key(input logic [63:0] k0, k1, k2, k3);
      write_key(CsrKeyWord0, k0);
      write_key(CsrKeyWord1, k1);
      write_key(CsrKeyWord2, k2);
      write_key(CsrKeyWord3, k3);
   endtask

   function automatic logic [63:0] rand64();
      return {$urandom(), $urandom()};
   endfunction

   task automatic test_reset_key();
      send_block('0, '0, 1'b0);
      send_block('1, '1, 1'b0);
      drain();
   endtask

   task automatic test_known_vector();
      // standard aes-256 vector: key 00..1f, plaintext 00112233..ff
      load_key(64'h0706050403020100, 64'h0f0e0d0c0b0a0908,
               64'h1716151413121110, 64'h1f1e1d1c1b1a1918);
      send_block(64'h7766554433221100, 64'hffeeddccbbaa9988, 1'b0);
      send_block('0, '1, 1'b0);
      send_block('1, '0, 1'b0);
      send_block(64'h8000000000000001, 64'h0000000000000080, 1'b1);
      send_block(64'haaaaaaaaaaaaaaaa, 64'h5555555555555555, 1'b0);
      drain();
   endtask

   task automatic test_key_extremes();
      load_key('1, '1, '1, '1);
      send_block('0, '0, 1'b0);
      send_block('1, '1, 1'b0);
      drain();
      load_key('0, '0, '0, '1);
      send_block(64'h0123456789abcdef, 64'hfedcba9876543210, 1'b0);
      drain();
      write_key(CsrKeyWord2, 64'h5555555555555555);
      send_block(64'h0123456789abcdef, 64'hfedcba9876543210, 1'b0);
      drain();
   endtask

   task automatic test_random_traffic();
      for (int phase = 0; phase < 6; phase++) begin
         load_key(rand64(), rand64(), rand64(), rand64());
         for (int i = 0; i < 100; i++) begin
            send_block(rand64(), rand64(), (phase % 2 == 0) || ($urandom_range(0, 3) == 0));
            // hold off until the pipeline has emptied
            if (i == 50) begin
               start <= 1'b0;
               @(posedge clock);
               while (ciphertext_queue.size() != 0) @(posedge clock);
            end
         end
         drain();
      end
   endtask

   initial begin
      for (int i = 0; i < 4; i++) key_copy[i] = '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      test_reset_key();
      test_known_vector();
      test_key_extremes();
      test_random_traffic();
      if (mismatch_count == 0 && ciphertext_queue.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end
endmodule
